### sv/tbdu_pkg.sv
// shared types and constants for the time base and decrementer unit
`timescale 1ns / 1ps

package tbdu_pkg;

   // request command codes
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_WR_TBL = 3'd1,
      CMD_WR_TBU = 3'd2,
      CMD_WR_DEC = 3'd3,
      CMD_RD_DEC = 3'd4,
      CMD_RD_TB  = 3'd5,
      CMD_POLL   = 3'd6
   } command_type;

   // poll result codes
   typedef enum logic [1:0] {
      EXC_NONE = 2'd0,
      EXC_EXT  = 2'd1,
      EXC_DEC  = 2'd2
   } exception_type;

   localparam int TB_WIDTH     = 64;
   localparam int DEC_WIDTH    = 32;
   localparam int REQ_BITS     = 37;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_BITS     = 67;
   localparam int RSP_DATA_W   = 72;

   // one decoded request
   typedef struct packed {
      logic                 ee_enabled;
      logic                 external_pending;
      logic [DEC_WIDTH-1:0] value;
      command_type          command;
   } request_type;

endpackage

### sv/tbdu_core.sv
// time base, decrementer deadline and armed flag with their update logic
`timescale 1ns / 1ps

module tbdu_core
   import tbdu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  request_type         request,
   output logic [TB_WIDTH-1:0] read_data,
   output exception_type       exception,
   output logic                irq_due
);

   logic [TB_WIDTH-1:0]  time_base_ff, time_base_in;
   logic [TB_WIDTH-1:0]  deadline_ff, deadline_in;
   logic                 armed_ff, armed_in;
   logic [DEC_WIDTH-1:0] dec_value;
   logic                 due_now;
   logic [DEC_WIDTH-1:0] tb_low;
   logic [DEC_WIDTH-1:0] tb_high;

   assign tb_low  = time_base_ff[DEC_WIDTH-1:0];
   assign tb_high = time_base_ff[TB_WIDTH-1:DEC_WIDTH];

   // decrementer is deadline - 1 - time base, only the low half matters
   assign dec_value = deadline_ff[DEC_WIDTH-1:0] - tb_low - DEC_WIDTH'(1);
   assign due_now   = armed_ff && (time_base_ff >= deadline_ff);
   assign irq_due   = due_now;

   // next state and read data for the request
   always_comb begin
      time_base_in = time_base_ff;
      deadline_in  = deadline_ff;
      armed_in     = armed_ff;
      read_data    = '0;
      exception    = EXC_NONE;
      case (request.command)
         CMD_TICK: begin
            time_base_in = time_base_ff + TB_WIDTH'(1);
         end
         CMD_WR_TBL: begin
            time_base_in = {tb_high, request.value};
            deadline_in  = deadline_ff + {{DEC_WIDTH{1'b0}}, request.value}
                           - {{DEC_WIDTH{1'b0}}, tb_low};
         end
         CMD_WR_TBU: begin
            time_base_in = {request.value, tb_low};
            deadline_in  = {deadline_ff[TB_WIDTH-1:DEC_WIDTH] + request.value - tb_high,
                            deadline_ff[DEC_WIDTH-1:0]};
         end
         CMD_WR_DEC: begin
            if (request.value[DEC_WIDTH-1]) begin
               // negative over non-negative fires at once
               armed_in    = !dec_value[DEC_WIDTH-1];
               deadline_in = time_base_ff;
            end else begin
               armed_in    = 1'b1;
               deadline_in = time_base_ff + {{DEC_WIDTH{1'b0}}, request.value}
                             + TB_WIDTH'(1);
            end
         end
         CMD_RD_DEC: begin
            read_data = {{DEC_WIDTH{1'b0}}, dec_value};
         end
         CMD_RD_TB: begin
            read_data = time_base_ff;
         end
         CMD_POLL: begin
            if (request.ee_enabled) begin
               if (request.external_pending) begin
                  exception = EXC_EXT;
               end else if (due_now) begin
                  armed_in  = 1'b0;
                  exception = EXC_DEC;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff <= '0;
         deadline_ff  <= '0;
         armed_ff     <= 1'b0;
      end else if (update) begin
         time_base_ff <= time_base_in;
         deadline_ff  <= deadline_in;
         armed_ff     <= armed_in;
      end
   end

endmodule

### sv/timebase_decrementer_unit_top.sv
// top level of the time base and decrementer unit with its stream pipeline
// path: an accepted request passes the input, middle and response registers in turn
// throughput: one request per cycle unless rsp_tready stalls; the state update
//   and the deadline compare each sit between their own pipeline registers
// reset: synchronous, clears time base, deadline, armed flag and all valids
`timescale 1ns / 1ps

module timebase_decrementer_unit_top
   import tbdu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: command[2:0], value[34:3], external_pending[35], ee_enabled[36]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: read_data[63:0], exception[65:64], irq_raise[66]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                 advance;
   logic                 req_valid_ff;
   request_type          req_ff;
   logic                 mid_valid_ff;
   logic [TB_WIDTH-1:0]  mid_data_ff;
   exception_type        mid_exc_ff;
   logic                 rsp_valid_ff;
   logic [RSP_BITS-1:0]  rsp_ff;
   logic [TB_WIDTH-1:0]  core_data;
   exception_type        core_exc;
   logic                 core_due;

   // whole pipeline moves when the response register is free or taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= request_type'(req_tdata[REQ_BITS-1:0]);
      end
   end

   tbdu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .update    (advance && req_valid_ff),
      .request   (req_ff),
      .read_data (core_data),
      .exception (core_exc),
      .irq_due   (core_due)
   );

   // middle stage, holds results while the state settles for the compare
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_data_ff <= core_data;
         mid_exc_ff  <= core_exc;
      end
   end

   // response register, irq sampled from the state after this request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= {core_due, mid_exc_ff, mid_data_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_ff};

endmodule
